// ===== rtl/vfr_pkg.sv =====
// Shared constants and types for the vertical FIR reduce block.
package vfr_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int MAX_TAPS_DEF      = 256;
  localparam int FRACTION_BITS_DEF = 12;

  localparam int ACC_W    = 32;
  localparam int PIXEL_W  = 8;
  localparam int COEF_W   = 16;
  localparam int COLUMN_W = 12;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int ROW_WIDTH_W = 13;
  localparam int TAP_COUNT_W = 9;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd4096;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 9'd1;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 8'd1;

  // per-item control tag from the sequencer to the accumulate stage
  typedef struct packed {
    logic first_tap;  // start the column from the rounding constant
    logic emit;       // last tap: produce a result
    logic last_col;   // last column of the row
  } ctl_t;

endpackage

// ===== rtl/vertical_fir_reduce_u8_unit.sv =====
// Top level of the vertical FIR reduce block.
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] pixel, tdata[23:8] coefficient
//  out_    | master    | tdata[7:0] value, tdata[19:8] column, tlast row_end
//  cfg_    | write     | index 0 row_width, 1 tap_count; data in cfg_data
//
// One item per cycle unless out_ stalls; a result is registered in the accumulate stage,
// then on out_. The per-column accumulator lives in one RAM (read at accept, written as
// the item leaves that stage); a one-column row hits the same entry back to back and is
// forwarded. Reset is synchronous, active low; it clears counters and the pipeline, the
// RAM is never cleared. A stalled out_ holds a last-tap item and drops in_tready.
module vertical_fir_reduce_u8_unit
  import vfr_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_TAPS      = MAX_TAPS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel, [23:8] coefficient
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] value, [19:8] column, rest zero
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic             accept;
  logic [CW-1:0]    col;
  ctl_t             ctl;
  logic             take_ready;
  logic [ACC_W-1:0] ram_q;
  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [ACC_W-1:0] wr_data;

  assign cfg_ready = 1'b1;
  assign in_tready = take_ready;
  assign accept    = in_tvalid && take_ready;

  vfr_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_TAPS  (MAX_TAPS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (col),
    .ctl       (ctl)
  );

  vfr_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_WIDTH)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ram_q)
  );

  vfr_mac #(
    .MAX_WIDTH     (MAX_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel       (in_tdata[PIXEL_W-1:0]),
    .coefficient (in_tdata[PIXEL_W +: COEF_W]),
    .col         (col),
    .ctl         (ctl),
    .take_ready  (take_ready),
    .ram_q       (ram_q),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== rtl/vfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module vfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/vfr_seq.sv =====
// Configuration registers and column/tap sequencer.
module vfr_seq
  import vfr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_TAPS  = MAX_TAPS_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  output logic [CW-1:0]          col,
  output ctl_t                   ctl
);

  localparam logic [16:0] MW = 17'(MAX_WIDTH);
  localparam logic [10:0] MT = 11'(MAX_TAPS);

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [TAP_COUNT_W-1:0] tap_count_r;
  logic [CW-1:0]          col_r, col_nxt;
  logic [TW-1:0]          tap_r, tap_nxt;
  logic [16:0]            rw_ext;
  logic [10:0]            tc_ext;
  logic [CW-1:0]          col_last;
  logic [TW-1:0]          tap_last;
  logic                   last_col, last_tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width_r <= cfg_data[ROW_WIDTH_W-1:0];
        REG_TAP_COUNT: tap_count_r <= cfg_data[TAP_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits: zero acts as one, oversize acts as the maximum
  always_comb begin
    rw_ext = 17'(row_width_r);
    tc_ext = 11'(tap_count_r);
    if (rw_ext == '0) begin
      col_last = '0;
    end else if (rw_ext > MW) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(rw_ext - 17'd1);
    end
    if (tc_ext == '0) begin
      tap_last = '0;
    end else if (tc_ext > MT) begin
      tap_last = TW'(MAX_TAPS - 1);
    end else begin
      tap_last = TW'(tc_ext - 11'd1);
    end
  end

  assign last_col = (col_r >= col_last);
  assign last_tap = (tap_r >= tap_last);

  always_comb begin
    col_nxt = col_r;
    tap_nxt = tap_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        tap_nxt = last_tap ? '0 : tap_r + TW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      tap_r <= '0;
    end else begin
      col_r <= col_nxt;
      tap_r <= tap_nxt;
    end
  end

  assign col           = col_r;
  assign ctl.first_tap = (tap_r == '0);
  assign ctl.emit      = last_tap;
  assign ctl.last_col  = last_col;

endmodule

// ===== rtl/vfr_mac.sv =====
// Accumulate stage: multiply, read-modify-write of the line store, clamp, output register.
module vfr_mac
  import vfr_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [PIXEL_W-1:0]     pixel,
  input  logic [COEF_W-1:0]      coefficient,
  input  logic [CW-1:0]          col,
  input  ctl_t                   ctl,
  output logic                   take_ready,
  input  logic [ACC_W-1:0]       ram_q,
  output logic                   wr_en,
  output logic [CW-1:0]          wr_addr,
  output logic [ACC_W-1:0]       wr_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRACTION_BITS - 1);

  logic                   s1_valid_r;
  logic [PIXEL_W-1:0]     s1_pixel_r;
  logic [COEF_W-1:0]      s1_coef_r;
  logic [CW-1:0]          s1_col_r;
  ctl_t                   s1_ctl_r;
  logic                   fwd_r;
  logic [ACC_W-1:0]       fwd_data_r;
  logic                   out_valid_r;
  logic [PIXEL_W-1:0]     out_value_r;
  logic [COLUMN_W-1:0]    out_col_r;
  logic                   out_last_r;

  logic                   s1_go, out_load;
  logic signed [24:0]     prod;
  logic [ACC_W-1:0]       base, acc;
  logic [PIXEL_W-1:0]     clamped;

  assign out_load   = s1_valid_r && s1_ctl_r.emit && (!out_valid_r || out_tready);
  assign s1_go      = s1_valid_r && (!s1_ctl_r.emit || !out_valid_r || out_tready);
  assign take_ready = !s1_valid_r || s1_go;

  always_comb begin
    prod = $signed({1'b0, s1_pixel_r}) * $signed(s1_coef_r);
    if (s1_ctl_r.first_tap) begin
      base = ROUND;
    end else if (fwd_r) begin
      base = fwd_data_r;
    end else begin
      base = ram_q;
    end
    acc = base + ACC_W'(prod);
    // clamp the arithmetic shift to 0..255
    if (acc[ACC_W-1]) begin
      clamped = '0;
    end else if (|acc[ACC_W-2:FRACTION_BITS+PIXEL_W]) begin
      clamped = '1;
    end else begin
      clamped = acc[FRACTION_BITS +: PIXEL_W];
    end
  end

  assign wr_en   = s1_go;
  assign wr_addr = s1_col_r;
  assign wr_data = acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        // same column written this edge: take the new sum instead of the RAM
        fwd_r      <= s1_go && (s1_col_r == col);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r <= pixel;
      s1_coef_r  <= coefficient;
      s1_col_r   <= col;
      s1_ctl_r   <= ctl;
      fwd_data_r <= acc;
    end
    if (out_load) begin
      out_value_r <= clamped;
      out_col_r   <= COLUMN_W'(s1_col_r);
      out_last_r  <= s1_ctl_r.last_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_col_r, out_value_r});
  assign out_tlast  = out_last_r;

endmodule
